// ===== sv/gdd_pkg.sv =====
// Shared types, constants and helpers of the grid detection decoder.
package gdd_pkg;

	localparam int NUM_CLASSES_DEF = 20;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int IN_W = 120;
	localparam int OUT_W = 136;
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;
	localparam int PROB_W = 16;

	localparam logic [2:0] REG_GRID_SIDE = 3'd0;
	localparam logic [2:0] REG_BOXES_PER_CELL = 3'd1;
	localparam logic [2:0] REG_SQUARE_SIZE = 3'd2;
	localparam logic [2:0] REG_IMAGE_WIDTH = 3'd3;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;
	localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd5;
	localparam logic [2:0] REG_OBJECTNESS_ONLY = 3'd6;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_BOX = 1'b1;

	localparam int DIV_W = 32;
	localparam int DIV_STEPS = 4;
	localparam int CELL_BITS = 12;

	typedef struct packed {
		logic [5:0] grid_side;
		logic [3:0] boxes_per_cell;
		logic square_size;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [15:0] score_threshold;
		logic objectness_only;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		grid_side: 6'd7,
		boxes_per_cell: 4'd2,
		square_size: 1'b0,
		image_width: 13'd1,
		image_height: 13'd1,
		score_threshold: 16'd13107,
		objectness_only: 1'b0
	};

	typedef struct packed {
		logic kind;
		logic [5:0] class_number;
		logic [15:0] class_probability;
		logic [12:0] box_slot;
		logic [23:0] center_x;
		logic [23:0] center_y;
		logic [23:0] box_width;
		logic [23:0] box_height;
		logic [15:0] objectness;
	} entry_t;

	typedef struct packed {
		logic [5:0] rem;
		logic [DIV_W-1:0] dvd;
	} div_state_t;

	// restoring division by a 6-bit divisor, DIV_STEPS quotient bits
	function automatic div_state_t div_steps(div_state_t st, logic [5:0] dvs);
		div_state_t r;
		logic [6:0] t;
		r = st;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {r.rem, r.dvd[DIV_W-1]};
			r.dvd = {r.dvd[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, dvs}) begin
				t = t - {1'b0, dvs};
				r.dvd[0] = 1'b1;
			end
			r.rem = t[5:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/gdd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gdd_ram import gdd_pkg::*; #(
	parameter int WIDTH = PROB_W,
	parameter int DEPTH = NUM_CLASSES_DEF
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/gdd_front.sv =====
// Front end: accepts words, splits the cell index and computes the scaled box.
module gdd_front import gdd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic s_tvalid,
	output logic s_tready,
	// class_number, class_probability, cell_index, box_in_cell, raw_x, raw_y,
	// raw_w, raw_h, objectness, zero pad
	input logic [IN_W-1:0] s_tdata,
	// kind
	input logic s_tuser,
	output logic push,
	output entry_t push_data,
	input logic q_full
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_CELL = 3'd1;
	localparam logic [2:0] F_MUL = 3'd2;
	localparam logic [2:0] F_PREP = 3'd3;
	localparam logic [2:0] F_CTR = 3'd4;
	localparam logic [2:0] F_PUSH = 3'd5;

	localparam int CELL_CYCLES = CELL_BITS / DIV_STEPS;
	localparam int CTR_CYCLES = DIV_W / DIV_STEPS;
	localparam int CNT_W = $clog2(CTR_CYCLES);
	localparam int BOX_LAT = CELL_CYCLES + CTR_CYCLES + 3;

	localparam logic signed [40:0] CTR_HI = 41'sd536870911;
	localparam logic signed [40:0] CTR_LO = -41'sd536870912;

	typedef struct packed {
		logic neg;
		div_state_t st;
	} ctr_t;

	function automatic logic [23:0] sat24(logic signed [47:0] v);
		if (v > 48'sd8388607) begin
			return 24'h7FFFFF;
		end
		if (v < -48'sd8388608) begin
			return 24'h800000;
		end
		return v[23:0];
	endfunction

	function automatic logic signed [31:0] size_base(logic [15:0] raw, logic sq);
		logic signed [31:0] r;
		r = 32'($signed(raw));
		return sq ? r * r : r;
	endfunction

	function automatic logic [23:0] size_round(logic signed [45:0] p, logic sq);
		logic signed [45:0] t;
		if (sq) begin
			t = (p + 46'sd524288) >>> 20;
		end else begin
			t = (p + 46'sd32) >>> 6;
		end
		return sat24(48'(t));
	endfunction

	function automatic ctr_t center_prep(logic signed [39:0] p, logic [5:0] s);
		logic signed [40:0] m;
		logic signed [40:0] x;
		ctr_t c;
		m = (41'(p) <<< 1) + $signed({29'd0, s, 6'd0});
		x = m >>> 7;
		if (x > CTR_HI) begin
			x = CTR_HI;
		end else if (x < CTR_LO) begin
			x = CTR_LO;
		end
		c.neg = x[40];
		if (c.neg) begin
			x = -x;
		end
		c.st.rem = '0;
		c.st.dvd = {2'd0, x[29:0]};
		return c;
	endfunction

	function automatic logic [23:0] center_fix(logic neg, div_state_t st);
		logic signed [33:0] q;
		q = $signed({2'd0, st.dvd});
		if (neg) begin
			q = -(q + ((st.rem != '0) ? 34'sd1 : 34'sd0));
		end
		return sat24(48'(q));
	endfunction

	logic [2:0] state_q;
	logic [CNT_W-1:0] cnt_q;
	logic accept;
	logic [5:0] side;

	logic [5:0] in_cls;
	logic [15:0] in_prob;
	logic [9:0] in_cell;
	logic [2:0] in_box;
	logic [15:0] in_rx;
	logic [15:0] in_ry;
	logic [15:0] in_rw;
	logic [15:0] in_rh;
	logic [15:0] in_obj;

	logic signed [15:0] rx_q;
	logic signed [15:0] ry_q;
	logic [15:0] obj_q;
	logic [12:0] slot_q;
	logic signed [31:0] vw_q;
	logic signed [31:0] vh_q;
	logic signed [39:0] px_q;
	logic signed [39:0] py_q;
	logic signed [45:0] pw_q;
	logic signed [45:0] ph_q;
	div_state_t xdiv_q;
	div_state_t ydiv_q;
	logic xneg_q;
	logic yneg_q;
	logic [23:0] bw_q;
	logic [23:0] bh_q;
	logic signed [25:0] nx;
	logic signed [25:0] ny;
	ctr_t cx_prep;
	ctr_t cy_prep;

	assign in_cls = s_tdata[5:0];
	assign in_prob = s_tdata[21:6];
	assign in_cell = s_tdata[31:22];
	assign in_box = s_tdata[34:32];
	assign in_rx = s_tdata[50:35];
	assign in_ry = s_tdata[66:51];
	assign in_rw = s_tdata[82:67];
	assign in_rh = s_tdata[98:83];
	assign in_obj = s_tdata[114:99];

	assign side = (cfg.grid_side == '0) ? 6'd1 : cfg.grid_side;
	assign s_tready = (state_q == F_IDLE) && !q_full;
	assign accept = s_tvalid && s_tready;

	assign nx = 26'(rx_q) + $signed({6'd0, xdiv_q.rem, 14'd0});
	assign ny = 26'(ry_q) + $signed({2'd0, xdiv_q.dvd[9:0], 14'd0});
	assign cx_prep = center_prep(px_q, side);
	assign cy_prep = center_prep(py_q, side);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && s_tuser == KIND_BOX) begin
						state_q <= F_CELL;
						cnt_q <= CNT_W'(CELL_CYCLES - 1);
					end
				end
				F_CELL: begin
					if (cnt_q == '0) begin
						state_q <= F_MUL;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				F_MUL: begin
					state_q <= F_PREP;
				end
				F_PREP: begin
					state_q <= F_CTR;
					cnt_q <= CNT_W'(CTR_CYCLES - 1);
				end
				F_CTR: begin
					if (cnt_q == '0) begin
						state_q <= F_PUSH;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_q <= $signed(in_rx);
			ry_q <= $signed(in_ry);
			obj_q <= in_obj;
			slot_q <= 13'(14'(in_cell) * 14'(cfg.boxes_per_cell)) + 13'(in_box);
			xdiv_q.rem <= '0;
			xdiv_q.dvd <= {2'd0, in_cell, {(DIV_W - CELL_BITS){1'b0}}};
			vw_q <= size_base(in_rw, cfg.square_size);
			vh_q <= size_base(in_rh, cfg.square_size);
		end
		if (state_q == F_CELL) begin
			xdiv_q <= div_steps(xdiv_q, side);
		end
		if (state_q == F_MUL) begin
			px_q <= nx * $signed({1'b0, cfg.image_width});
			py_q <= ny * $signed({1'b0, cfg.image_height});
			pw_q <= vw_q * $signed({1'b0, cfg.image_width});
			ph_q <= vh_q * $signed({1'b0, cfg.image_height});
		end
		if (state_q == F_PREP) begin
			xneg_q <= cx_prep.neg;
			xdiv_q <= cx_prep.st;
			yneg_q <= cy_prep.neg;
			ydiv_q <= cy_prep.st;
			bw_q <= size_round(pw_q, cfg.square_size);
			bh_q <= size_round(ph_q, cfg.square_size);
		end
		if (state_q == F_CTR) begin
			xdiv_q <= div_steps(xdiv_q, side);
			ydiv_q <= div_steps(ydiv_q, side);
		end
	end

	assign push = (accept && s_tuser == KIND_LOAD) || (state_q == F_PUSH && !q_full);

	always_comb begin
		push_data = '0;
		if (state_q == F_PUSH) begin
			push_data.kind = KIND_BOX;
			push_data.box_slot = slot_q;
			push_data.center_x = center_fix(xneg_q, xdiv_q);
			push_data.center_y = center_fix(yneg_q, ydiv_q);
			push_data.box_width = bw_q;
			push_data.box_height = bh_q;
			push_data.objectness = obj_q;
		end else begin
			push_data.kind = KIND_LOAD;
			push_data.class_number = in_cls;
			push_data.class_probability = in_prob;
		end
	end

	a_box_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == KIND_BOX |-> ##(BOX_LAT) (state_q == F_PUSH))
		else $error("box did not reach the push state on time");

endmodule

// ===== sv/gdd_queue.sv =====
// Short queue between the front end and the score emitter.
module gdd_queue import gdd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input entry_t push_data,
	output logic full,
	input logic pop,
	output entry_t pop_data,
	output logic valid
);

	localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t mem_q [DEPTH];
	logic [PW-1:0] rd_q;
	logic [PW-1:0] wr_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("queue underflow");

endmodule

// ===== sv/gdd_back.sv =====
// Back end: class store and per-class score emission with the output register.
module gdd_back import gdd_pkg::*; #(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic q_valid,
	input entry_t q_data,
	output logic q_pop,
	output logic m_tvalid,
	input logic m_tready,
	// box_slot, center_x, center_y, box_width, box_height, class_id, score, zero pad
	output logic [OUT_W-1:0] m_tdata,
	output logic m_tlast
);

	localparam int CW = NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1;
	localparam logic [CW-1:0] LAST_K = CW'(NUM_CLASSES - 1);

	logic busy_q;
	logic [CW-1:0] k_q;
	entry_t box_q;
	logic valid_s1;
	logic [CW-1:0] k_s1;
	logic out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic out_last_q;

	logic out_free;
	logic s1_adv;
	logic issue;
	logic we;
	logic [PROB_W-1:0] rdata;
	logic [31:0] prod;
	logic [15:0] score;

	assign out_free = !out_valid_q || m_tready;
	assign s1_adv = valid_s1 && out_free;
	assign issue = busy_q && (!valid_s1 || s1_adv);
	assign q_pop = q_valid && !busy_q && !valid_s1;
	assign we = q_pop && q_data.kind == KIND_LOAD &&
		({1'b0, q_data.class_number} < 7'(NUM_CLASSES));

	gdd_ram #(
		.WIDTH(PROB_W),
		.DEPTH(NUM_CLASSES)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(q_data.class_number[CW-1:0]),
		.wdata(q_data.class_probability),
		.re(issue),
		.raddr(k_q),
		.rdata(rdata)
	);

	assign prod = 32'(box_q.objectness) * 32'(rdata);

	always_comb begin
		score = prod[31:16];
		if (score <= cfg.score_threshold) begin
			score = '0;
		end
		if (k_s1 == '0 && cfg.objectness_only) begin
			score = box_q.objectness;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= '0;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && q_data.kind == KIND_BOX) begin
				busy_q <= 1'b1;
				k_q <= '0;
			end else if (issue) begin
				if (k_q == LAST_K) begin
					busy_q <= 1'b0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.kind == KIND_BOX) begin
			box_q <= q_data;
		end
		if (issue) begin
			k_s1 <= k_q;
		end
		if (s1_adv) begin
			out_data_q <= {5'd0, score, 6'(k_s1), box_q.box_height, box_q.box_width,
				box_q.center_y, box_q.center_x, box_q.box_slot};
			out_last_q <= (k_s1 == LAST_K);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tlast = out_last_q;

	a_last_read_ends_box: assert property (@(posedge clk) disable iff (!arst_n)
		issue && k_q == LAST_K |=> !busy_q)
		else $error("box still busy after its last class read");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(k_s1))
		else $error("read stage moved while the output was blocked");

endmodule

// ===== sv/grid_detection_decoder.sv =====
// Top level of the grid detection decoder: register file and block wiring.
//
// channel  direction  handshake                  contents
// s_*      in         s_tvalid / s_tready        tuser kind; tdata load or box fields
// m_*      out        m_tvalid / m_tready        tdata one class result; tlast on last class
// apb      in         psel, penable, pwrite      seven registers at byte address 4*i
//
// A load word is pushed to the queue in the cycle it is accepted. A box word goes
// through the cell row/column split, multiply and round steps and the center
// divide by grid side, both divides on a 6-bit restoring divider at four bits per
// cycle; no new word is taken until the box is pushed. The back end reads the class
// store one entry per cycle unless the output stalls, NUM_CLASSES results per box.
// arst_n clears control state and loads the register reset values; the class store
// is not cleared. A low m_tready holds the output register, fills the queue and
// then drops s_tready.
module grid_detection_decoder import gdd_pkg::*; #(
	parameter int NUM_CLASSES = NUM_CLASSES_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// class_number, class_probability, cell_index, box_in_cell, raw_x, raw_y,
	// raw_w, raw_h, objectness, zero pad
	input logic [IN_W-1:0] s_tdata,
	// kind
	input logic s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// box_slot, center_x, center_y, box_width, box_height, class_id, score, zero pad
	output logic [OUT_W-1:0] m_tdata,
	output logic m_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CFG_AW-1:0] paddr,
	input logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic pready
);

	cfg_t cfg_q;
	logic [2:0] reg_idx;
	logic cfg_wr;
	logic push;
	entry_t push_data;
	logic q_full;
	logic q_pop;
	entry_t q_data;
	logic q_valid;

	assign pready = 1'b1;
	assign reg_idx = paddr[CFG_AW-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_GRID_SIDE: cfg_q.grid_side <= pwdata[5:0];
				REG_BOXES_PER_CELL: cfg_q.boxes_per_cell <= pwdata[3:0];
				REG_SQUARE_SIZE: cfg_q.square_size <= pwdata[0];
				REG_IMAGE_WIDTH: cfg_q.image_width <= pwdata[12:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[12:0];
				REG_SCORE_THRESHOLD: cfg_q.score_threshold <= pwdata[15:0];
				REG_OBJECTNESS_ONLY: cfg_q.objectness_only <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GRID_SIDE: prdata = CFG_DW'(cfg_q.grid_side);
			REG_BOXES_PER_CELL: prdata = CFG_DW'(cfg_q.boxes_per_cell);
			REG_SQUARE_SIZE: prdata = CFG_DW'(cfg_q.square_size);
			REG_IMAGE_WIDTH: prdata = CFG_DW'(cfg_q.image_width);
			REG_IMAGE_HEIGHT: prdata = CFG_DW'(cfg_q.image_height);
			REG_SCORE_THRESHOLD: prdata = CFG_DW'(cfg_q.score_threshold);
			REG_OBJECTNESS_ONLY: prdata = CFG_DW'(cfg_q.objectness_only);
			default: prdata = '0;
		endcase
	end

	gdd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.push(push),
		.push_data(push_data),
		.q_full(q_full)
	);

	gdd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(q_full),
		.pop(q_pop),
		.pop_data(q_data),
		.valid(q_valid)
	);

	gdd_back #(
		.NUM_CLASSES(NUM_CLASSES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_data(q_data),
		.q_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

// ===== test/grid_detection_decoder_tb.sv =====
// Self-checking testbench of the grid detection decoder: loads, box decodes, register phases.
module grid_detection_decoder_tb import gdd_pkg::*;;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic kind;
		logic [5:0] class_number;
		logic [15:0] class_probability;
		logic [9:0] cell_index;
		logic [2:0] box_in_cell;
		logic [15:0] raw_x;
		logic [15:0] raw_y;
		logic [15:0] raw_w;
		logic [15:0] raw_h;
		logic [15:0] objectness;
	} in_word_t;

	localparam int IN_WORD_W = $bits(in_word_t);

	typedef struct packed {
		logic [12:0] box_slot;
		logic [23:0] center_x;
		logic [23:0] center_y;
		logic [23:0] box_width;
		logic [23:0] box_height;
		logic [5:0] class_id;
		logic [15:0] score;
		logic last;
	} class_result_t;

	class decode_scoreboard;
		cfg_t cfg;
		logic [15:0] class_prob [NUM_CLASSES_DEF];
		class_result_t results_due [$];
		int errors;

		function new();
			cfg = CFG_RESET;
			errors = 0;
			foreach (class_prob[i])
				class_prob[i] = '0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_GRID_SIDE: cfg.grid_side = value[5:0];
				REG_BOXES_PER_CELL: cfg.boxes_per_cell = value[3:0];
				REG_SQUARE_SIZE: cfg.square_size = value[0];
				REG_IMAGE_WIDTH: cfg.image_width = value[12:0];
				REG_IMAGE_HEIGHT: cfg.image_height = value[12:0];
				REG_SCORE_THRESHOLD: cfg.score_threshold = value[15:0];
				REG_OBJECTNESS_ONLY: cfg.objectness_only = value[0];
				default: ;
			endcase
		endfunction

		function int due();
			return results_due.size();
		endfunction

		// nearest, ties toward +inf
		function longint round_near(longint n, longint d);
			longint a, b, q;
			a = 2 * n + d;
			b = 2 * d;
			q = a / b;
			if ((a % b) != 0 && a < 0)
				q--;
			return q;
		endfunction

		function logic [23:0] clamp24(longint v);
			if (v > 64'sd8388607)
				v = 64'sd8388607;
			if (v < -64'sd8388608)
				v = -64'sd8388608;
			return v[23:0];
		endfunction

		function logic [23:0] center_px(logic [15:0] raw, longint pos, longint side,
				longint scale);
			longint n;
			n = $signed(raw);
			n = n + pos * 16384;
			return clamp24(round_near(n * scale, side * 64));
		endfunction

		function logic [23:0] size_px(logic [15:0] raw, longint scale);
			longint r;
			r = $signed(raw);
			if (cfg.square_size)
				return clamp24(round_near(r * r * scale, longint'(1) << 20));
			return clamp24(round_near(r * scale, 64));
		endfunction

		function void note_word(in_word_t w);
			longint side, row, col, slot;
			logic [31:0] prod;
			logic [15:0] s;
			class_result_t r;
			if (w.kind == KIND_LOAD) begin
				if (w.class_number < NUM_CLASSES_DEF)
					class_prob[w.class_number] = w.class_probability;
				return;
			end
			side = (cfg.grid_side == 0) ? 1 : cfg.grid_side;
			row = w.cell_index / side;
			col = w.cell_index % side;
			slot = longint'(w.cell_index) * cfg.boxes_per_cell + w.box_in_cell;
			r.box_slot = slot[12:0];
			r.center_x = center_px(w.raw_x, col, side, cfg.image_width);
			r.center_y = center_px(w.raw_y, row, side, cfg.image_height);
			r.box_width = size_px(w.raw_w, cfg.image_width);
			r.box_height = size_px(w.raw_h, cfg.image_height);
			for (int k = 0; k < NUM_CLASSES_DEF; k++) begin
				prod = w.objectness * class_prob[k];
				s = prod[31:16];
				if (s <= cfg.score_threshold)
					s = '0;
				if (k == 0 && cfg.objectness_only)
					s = w.objectness;
				r.class_id = k[5:0];
				r.score = s;
				r.last = (k == NUM_CLASSES_DEF - 1);
				results_due.push_back(r);
			end
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(class_result_t got);
			class_result_t want;
			if (results_due.size() == 0) begin
				$error("unexpected result: slot 0x%0h class %0d", got.box_slot, got.class_id);
				errors++;
				return;
			end
			want = results_due.pop_front();
			compare("box_slot", want.box_slot, got.box_slot);
			compare("center_x", want.center_x, got.center_x);
			compare("center_y", want.center_y, got.center_y);
			compare("box_width", want.box_width, got.box_width);
			compare("box_height", want.box_height, got.box_height);
			compare("class_id", want.class_id, got.class_id);
			compare("score", want.score, got.score);
			compare("last", want.last, got.last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [CFG_DW-1:0] pwdata = '0;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	decode_scoreboard sb;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;

	grid_detection_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready = ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		class_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.box_slot = m_tdata[12:0];
			got.center_x = m_tdata[36:13];
			got.center_y = m_tdata[60:37];
			got.box_width = m_tdata[84:61];
			got.box_height = m_tdata[108:85];
			got.class_id = m_tdata[114:109];
			got.score = m_tdata[130:115];
			got.last = m_tlast;
			sb.check_result(got);
		end
	end

	function automatic in_word_t load_word(logic [5:0] cls, logic [15:0] prob);
		in_word_t w;
		w = IN_WORD_W'({$urandom, $urandom, $urandom, $urandom});
		w.kind = KIND_LOAD;
		w.class_number = cls;
		w.class_probability = prob;
		return w;
	endfunction

	function automatic in_word_t box_word(logic [9:0] cell_idx, logic [2:0] bx,
			logic [15:0] x, logic [15:0] y, logic [15:0] bw, logic [15:0] bh,
			logic [15:0] obj);
		in_word_t w;
		w.kind = KIND_BOX;
		w.class_number = 6'($urandom_range(63));
		w.class_probability = 16'($urandom_range(65535));
		w.cell_index = cell_idx;
		w.box_in_cell = bx;
		w.raw_x = x;
		w.raw_y = y;
		w.raw_w = bw;
		w.raw_h = bh;
		w.objectness = obj;
		return w;
	endfunction

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(3))
			0: return 16'($urandom_range(65535));
			3: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom_range(16384));
		endcase
	endfunction

	function automatic logic [15:0] pick_q16();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	function automatic in_word_t random_word();
		int side;
		logic [9:0] cell_idx;
		if ($urandom_range(99) < 45) begin
			if ($urandom_range(99) < 85)
				return load_word(6'($urandom_range(NUM_CLASSES_DEF - 1)), pick_q16());
			return load_word(6'($urandom_range(63)), pick_q16());
		end
		side = (sb.cfg.grid_side == 0) ? 1 : sb.cfg.grid_side;
		if ($urandom_range(1))
			cell_idx = 10'($urandom_range(1023));
		else
			cell_idx = 10'($urandom_range((side * side > 1024) ? 1023 : side * side - 1));
		return box_word(cell_idx, 3'($urandom_range(7)), pick_raw(), pick_raw(), pick_raw(),
			pick_raw(), pick_q16());
	endfunction

	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = w.kind;
		s_tdata = {5'b0, w.objectness, w.raw_h, w.raw_w, w.raw_y, w.raw_x, w.box_in_cell,
			w.cell_index, w.class_probability, w.class_number};
		do @(posedge clk); while (!s_tready);
		sb.note_word(w);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apply_setting(input int ph);
		case (ph)
			1: begin
				cfg_write(REG_GRID_SIDE, 1);
				cfg_write(REG_BOXES_PER_CELL, 1);
				cfg_write(REG_SQUARE_SIZE, 0);
				cfg_write(REG_IMAGE_WIDTH, 4096);
				cfg_write(REG_IMAGE_HEIGHT, 4096);
				cfg_write(REG_SCORE_THRESHOLD, 0);
				cfg_write(REG_OBJECTNESS_ONLY, 1);
			end
			2: begin
				cfg_write(REG_GRID_SIDE, 32);
				cfg_write(REG_BOXES_PER_CELL, 8);
				cfg_write(REG_SQUARE_SIZE, 1);
				cfg_write(REG_IMAGE_WIDTH, 4096);
				cfg_write(REG_IMAGE_HEIGHT, 1);
				cfg_write(REG_SCORE_THRESHOLD, 65535);
				cfg_write(REG_OBJECTNESS_ONLY, 0);
			end
			default: begin
				cfg_write(REG_GRID_SIDE, 0);
				cfg_write(REG_BOXES_PER_CELL, 3);
				cfg_write(REG_SQUARE_SIZE, 1);
				cfg_write(REG_IMAGE_WIDTH, 1);
				cfg_write(REG_IMAGE_HEIGHT, 2777);
				cfg_write(REG_SCORE_THRESHOLD, 9000);
				cfg_write(REG_OBJECTNESS_ONLY, 1);
				cfg_write(REG_UNUSED, 32'h0000_003F);
			end
		endcase
	endtask

	task automatic run_directed();
		// fill every class entry before the first box reads it
		for (int k = 0; k < NUM_CLASSES_DEF; k++) begin
			case (k)
				0: send_word(load_word(6'(k), 16'hFFFF));
				1: send_word(load_word(6'(k), 16'h0000));
				2: send_word(load_word(6'(k), 16'h8000));
				3: send_word(load_word(6'(k), 16'h3334));
				4: send_word(load_word(6'(k), 16'h3333));
				default: send_word(load_word(6'(k), 16'($urandom_range(65535))));
			endcase
		end
		send_word(load_word(6'd63, 16'hAAAA));
		send_word(box_word(10'd1023, 3'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
		send_word(box_word(10'd0, 3'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000));
		send_word(box_word(10'd48, 3'd1, 16'h4000, 16'h0000, 16'hFFFF, 16'h2000, 16'h8000));
		send_word(box_word(10'd24, 3'd2, pick_raw(), pick_raw(), pick_raw(), pick_raw(),
			16'hFFFF));
	endtask

	task automatic run_random(input int target);
		in_word_t w;
		int n;
		n = 0;
		while (n < target) begin
			w = random_word();
			send_word(w);
			if (!(w.kind == KIND_LOAD && w.class_number >= NUM_CLASSES_DEF))
				n++;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (sb.due() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		sb = new();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 47 : 0;
			recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 33 : 0;
			if (ph == 0)
				run_directed();
			else
				apply_setting(ph);
			run_random((ph == 0) ? 22 : 21);
			s_tvalid = 1'b0;
			wait_drained();
		end
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
